### rtl/core/cdio_pkg.sv
// Shared types, constants and helpers for the colour display I/O decoder.
`default_nettype none

package cdio_pkg;

    localparam int COLOUR_CELL_COUNT = 64;
    localparam int CELL_AW = $clog2(COLOUR_CELL_COUNT);

    typedef enum logic [1:0] {
        OP_MEM_WRITE = 2'd0,
        OP_INPUT     = 2'd1,
        OP_OUTPUT    = 2'd2,
        OP_LOOKUP    = 2'd3
    } op_t;

    localparam logic [0:0] REG_MACHINE_KIND = 1'b0;

    localparam logic [11:0] RAM_BASE    = 12'h800;
    localparam logic [11:0] RAM_LIMIT   = 12'hA00;
    localparam logic [3:0]  COLOUR_PAGE = 4'hB;

    localparam logic [2:0] PORT_SCREEN = 3'd1;
    localparam logic [2:0] PORT_KEYPAD = 3'd2;
    localparam logic [2:0] PORT_BLANK  = 3'd4;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] idx;
        logic [2:0]         data;
    } cell_wr_t;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] idx;
    } cell_rd_t;

    function automatic logic [2:0] back_rgb(input logic [1:0] step);
        logic [2:0] c;
        case (step)
            2'd0:    c = 3'd1;
            2'd1:    c = 3'd0;
            2'd2:    c = 3'd2;
            2'd3:    c = 3'd4;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    // stored order: bit0 red, bit1 blue, bit2 green
    function automatic logic [2:0] rbg_to_rgb(input logic [2:0] c);
        return {c[0], c[2], c[1]};
    endfunction

endpackage

`default_nettype wire

### rtl/core/cdio_cell_store.sv
// Colour cell store: 64 x 3 synchronous memory with per-cell valid bits.
`default_nettype none

module cdio_cell_store
    import cdio_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cell_wr_t wr,
    input  wire cell_rd_t rd,
    output logic [2:0]    rd_data
);

    logic [2:0]                   mem [COLOUR_CELL_COUNT];
    logic [COLOUR_CELL_COUNT-1:0] valid_reg;
    logic [COLOUR_CELL_COUNT-1:0] valid_next;
    logic [2:0]                   rd_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
    end

    // never-written cells read as zero
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= valid_reg[rd.idx] ? mem[rd.idx] : 3'd0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/colour_display_io_decoder.sv
// Colour display I/O decoder top level: request decode, display state and output register.
//
// One request is decoded per pass: a memory write, an input port access, an output
// port access or a colour lookup, each giving one result. The accept cycle issues the
// colour store access and updates the display state, the next cycle loads the result
// register with the registered store read. The next request is taken in the cycle the
// result leaves. The colour store is cleared at reset through per-cell valid bits, so
// no clearing pass is needed. machine_kind (register 0, address 0x0) selects colour
// behavior.
`default_nettype none

module colour_display_io_decoder
    import cdio_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // address[15:0], data[23:16], port[26:24], display_offset[34:27], zero pad
    input  wire logic [39:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // dot_rgb[2:0], background_rgb[5:3], colour_on[6], screen_on[7],
    // key_latch[11:8], ram_write[12], ram_index[21:13], zero pad[31:22]
    output logic [31:0]      m_tdata
);

    logic        machine_kind_reg, machine_kind_next;
    logic [1:0]  back_step_reg, back_step_next;
    logic        colour_en_reg, colour_en_next;
    logic        screen_en_reg, screen_en_next;
    logic [3:0]  keypad_reg, keypad_next;
    logic        pending_reg, pending_next;
    logic        out_valid_reg, out_valid_next;
    logic        lookup_reg;
    logic        ram_write_reg;
    logic [8:0]  ram_index_reg;
    logic [31:0] out_data_reg;

    logic        accept;
    logic        cfg_write;
    op_t         op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [2:0]  port;
    logic [7:0]  offs;
    logic        ram_hit;
    logic        colour_hit;
    cell_wr_t    cell_wr;
    cell_rd_t    cell_rd;
    logic [2:0]  cell_rd_data;
    logic [2:0]  dot;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MACHINE_KIND) ? {31'd0, machine_kind_reg} : 32'd0;

    assign s_tready = !pending_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign op   = op_t'(s_tuser);
    assign addr = s_tdata[11:0];
    assign data = s_tdata[23:16];
    assign port = s_tdata[26:24];
    assign offs = s_tdata[34:27];

    assign ram_hit    = (addr >= RAM_BASE) && (addr < RAM_LIMIT);
    assign colour_hit = machine_kind_reg && (addr[11:8] == COLOUR_PAGE);

    always_comb
    begin
        cell_wr.en   = accept && (op == OP_MEM_WRITE) && !ram_hit && colour_hit;
        cell_wr.idx  = addr[CELL_AW-1:0];
        cell_wr.data = data[2:0];
        cell_rd.en   = accept && (op == OP_LOOKUP);
        cell_rd.idx  = {offs[7:5], offs[2:0]};
    end

    cdio_cell_store u_cell_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cell_wr),
        .rd      (cell_rd),
        .rd_data (cell_rd_data)
    );

    always_comb
    begin
        machine_kind_next = machine_kind_reg;
        back_step_next    = back_step_reg;
        colour_en_next    = colour_en_reg;
        screen_en_next    = screen_en_reg;
        keypad_next       = keypad_reg;
        if (cfg_write && (paddr[2] == REG_MACHINE_KIND))
        begin
            machine_kind_next = pwdata[0];
        end
        if (accept)
        begin
            case (op)
                OP_MEM_WRITE:
                begin
                    if (cell_wr.en)
                    begin
                        colour_en_next = 1'b1;
                    end
                end
                OP_INPUT:
                begin
                    if (port == PORT_SCREEN)
                    begin
                        screen_en_next = 1'b1;
                    end
                    else if (port == PORT_BLANK && machine_kind_reg)
                    begin
                        screen_en_next = 1'b0;
                    end
                end
                OP_OUTPUT:
                begin
                    if (port == PORT_SCREEN)
                    begin
                        if (machine_kind_reg)
                        begin
                            back_step_next = back_step_reg + 2'd1;
                        end
                        else
                        begin
                            screen_en_next = 1'b0;
                        end
                    end
                    else if (port == PORT_KEYPAD)
                    begin
                        keypad_next = data[3:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pending_next   = accept;
        out_valid_next = out_valid_reg;
        if (pending_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            machine_kind_reg <= 1'b0;
            back_step_reg    <= 2'd0;
            colour_en_reg    <= 1'b0;
            screen_en_reg    <= 1'b0;
            keypad_reg       <= 4'd0;
            pending_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            machine_kind_reg <= machine_kind_next;
            back_step_reg    <= back_step_next;
            colour_en_reg    <= colour_en_next;
            screen_en_reg    <= screen_en_next;
            keypad_reg       <= keypad_next;
            pending_reg      <= pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lookup_reg    <= (op == OP_LOOKUP);
            ram_write_reg <= (op == OP_MEM_WRITE) && ram_hit;
            ram_index_reg <= ((op == OP_MEM_WRITE) && ram_hit) ? addr[8:0] : 9'd0;
        end
    end

    assign dot = lookup_reg ? rbg_to_rgb(cell_rd_data) : 3'd0;

    always_ff @(posedge clk)
    begin
        if (pending_reg)
        begin
            out_data_reg <= {2'd0, 8'd0, ram_index_reg, ram_write_reg, keypad_reg,
                             screen_en_reg, colour_en_reg, back_rgb(back_step_reg), dot};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(pending_reg && out_valid_reg))
        else $error("request in flight while result register is full");

    a_accept_to_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pending_reg)
        else $error("accepted request not in flight");

    a_pending_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |=> (out_valid_reg && !pending_reg))
        else $error("request in flight did not reach result register");

    a_ram_no_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |-> (m_tdata[2:0] == 3'd0))
        else $error("memory write result carries a dot colour");

endmodule

`default_nettype wire
